/* design/cfm_pkg.sv */
// Shared widths, reset value and result type of the capture frequency meter.
package cfm_pkg;

  localparam int unsigned ChanW           = 2;
  localparam int unsigned CapW            = 16;
  localparam int unsigned FreqW           = 31;
  localparam int unsigned ClkW            = 32;
  localparam int unsigned ChannelsDefault = 4;
  localparam int unsigned DivCntW         = $clog2(FreqW);

  localparam logic [ClkW-1:0] ClkReset = 32'd168000000;

  // One completed measurement
  typedef struct packed {
    logic [ChanW-1:0] channel_out;
    logic [CapW-1:0]  period_ticks;
    logic [FreqW-1:0] frequency_hz;
    logic             zero_period;
  } res_t;

endpackage

/* design/cfm_if.sv */
// Handshake channels of the capture frequency meter: captures, results, clock register.
interface cfm_cap_if;
  logic                      valid;
  logic                      ready;
  logic [cfm_pkg::ChanW-1:0] channel;
  logic [cfm_pkg::CapW-1:0]  capture_value;

  modport source (output valid, output channel, output capture_value, input ready);
  modport sink   (input valid, input channel, input capture_value, output ready);
endinterface

interface cfm_res_if;
  logic                      valid;
  logic                      ready;
  logic [cfm_pkg::ChanW-1:0] channel_out;
  logic [cfm_pkg::CapW-1:0]  period_ticks;
  logic [cfm_pkg::FreqW-1:0] frequency_hz;
  logic                      zero_period;

  modport source (output valid, output channel_out, output period_ticks,
                  output frequency_hz, output zero_period, input ready);
  modport sink   (input valid, input channel_out, input period_ticks,
                  input frequency_hz, input zero_period, output ready);
endinterface

interface cfm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [cfm_pkg::ClkW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/cfm_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module cfm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cfm_pkg::FreqW-1:0] dividend_i,
  input  logic [cfm_pkg::CapW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [cfm_pkg::FreqW-1:0] quotient_o
);
  import cfm_pkg::*;

  logic [CapW-1:0]    rem_q, rem_d;
  logic [FreqW-1:0]   quo_q, quo_d;
  logic [CapW-1:0]    div_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CapW:0]      trial;
  logic [CapW:0]      diff;
  logic               ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem_q, quo_q[FreqW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
  end

  // Step the shared subtractor until every quotient bit is out
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = DivCntW'(FreqW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[CapW-1:0] : trial[CapW-1:0];
      quo_d = {quo_q[FreqW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/cfm_ctrl.sv */
// Per-channel capture store and sequencer that drives the shared divider.
module cfm_ctrl #(
  parameter int unsigned CHANNELS = cfm_pkg::ChannelsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  cfm_cap_if.sink                   cap_i,
  output logic                      div_start_o,
  output logic [cfm_pkg::CapW-1:0]  div_divisor_o,
  input  logic                      div_done_i,
  input  logic [cfm_pkg::FreqW-1:0] div_quotient_i,
  input  logic                      slot_free_i,
  output logic                      push_o,
  output cfm_pkg::res_t             res_o
);
  import cfm_pkg::*;

  localparam int unsigned ChanIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CHANNELS-1:0] waiting_q;
  logic [CapW-1:0]   first_q [CHANNELS];
  logic [ChanW-1:0]  ch_q;
  logic [CapW-1:0]   period_q;
  logic              zero_q;

  logic              accept;
  logic              ch_ok;
  logic [ChanIdxW-1:0] idx;
  logic [CapW-1:0]   first_sel;
  logic              completes;
  logic [CapW-1:0]   period;

  // Decode the incoming beat
  always_comb begin
    cap_i.ready = (state_q == S_IDLE);
    accept      = cap_i.valid && cap_i.ready;
    ch_ok       = (32'(cap_i.channel) < 32'(CHANNELS));
    idx         = ChanIdxW'(cap_i.channel);
    first_sel   = first_q[idx];
    completes   = accept && ch_ok && waiting_q[idx];
  end

  // Wrapped tick difference; a wrap loses one tick
  always_comb begin
    if (cap_i.capture_value > first_sel) begin
      period = cap_i.capture_value - first_sel;
    end else if (cap_i.capture_value < first_sel) begin
      period = cap_i.capture_value - first_sel - 16'd1;
    end else begin
      period = '0;
    end
  end

  assign div_start_o   = completes && (period != '0);
  assign div_divisor_o = period;

  // Sequence: accept, divide unless the period is zero, hand the result over
  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (completes) begin
          state_d = (period == '0) ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done_i) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o.channel_out  = ch_q;
    res_o.period_ticks = period_q;
    res_o.frequency_hz = zero_q ? '0 : div_quotient_i;
    res_o.zero_period  = zero_q;
  end

  // Channel store: first beat stores, second beat clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      waiting_q <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        first_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept && ch_ok) begin
        waiting_q[idx] <= !waiting_q[idx];
        if (!waiting_q[idx]) begin
          first_q[idx] <= cap_i.capture_value;
        end
      end
    end
  end

  // Hold the pending measurement
  always_ff @(posedge clk_i) begin
    if (completes) begin
      ch_q     <= cap_i.channel;
      period_q <= period;
      zero_q   <= (period == '0);
    end
  end

  a_push_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> slot_free_i)
    else $error("result pushed into a full output register");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_o |=> (state_q == S_DIV) && !cap_i.ready)
    else $error("divider started but sequencer did not wait for it");

  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after hand-over");

endmodule

/* design/capture_frequency_meter.sv */
// Capture frequency meter: the first capture of a pair is stored and the capture
// side stays ready. A completing capture with nonzero period passes through start,
// 31 divider steps, done and hand-over to the output register before the next beat
// is taken; a zero period skips the divider and goes straight to the hand-over.
// Capture side not ready meanwhile; a full output register stalls it.
// Reset: every channel expects a first capture, stores 0, clock register 168000000.
module capture_frequency_meter #(
  parameter int unsigned CHANNELS = cfm_pkg::ChannelsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  cfm_cap_if.sink   cap_i,
  cfm_res_if.source res_o,
  cfm_cfg_if.sink   cfg_i
);
  import cfm_pkg::*;

  logic [ClkW-1:0]  clk_hz_q;
  logic             div_start;
  logic [CapW-1:0]  div_divisor;
  logic             div_done;
  logic [FreqW-1:0] div_quotient;
  logic             slot_free;
  logic             push;
  res_t             res;
  res_t             out_q;
  logic             out_valid_q;

  // Clock register, written any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      clk_hz_q <= cfg_i.data;
    end
  end

  cfm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clk_hz_q[ClkW-1:1]),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  cfm_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cap_i          (cap_i),
    .div_start_o    (div_start),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quotient_i (div_quotient),
    .slot_free_i    (slot_free),
    .push_o         (push),
    .res_o          (res)
  );

  // Output register: load a new beat or drop the taken one
  assign slot_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.channel_out  = out_q.channel_out;
  assign res_o.period_ticks = out_q.period_ticks;
  assign res_o.frequency_hz = out_q.frequency_hz;
  assign res_o.zero_period  = out_q.zero_period;

endmodule
